// File: rtl/core/csmc_pkg.sv
// shared types, constants and helpers for the counting scale mode controller
package csmc_pkg;

    localparam int CNT_W            = 23;
    localparam int WEIGHT_BITS_DEF  = 24;
    localparam logic [CNT_W-1:0] MAX_CNT        = 23'h7FFFFF;
    localparam logic [CNT_W-1:0] MIN_SAMPLE_RST = 23'd1000;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_TARE   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_TOGGLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_WEIGH = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_ERROR = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        ST_INIT           = 4'd0,
        ST_OVERLOAD       = 4'd1,
        ST_NO_PIECE       = 4'd2,
        ST_UNSTABLE       = 4'd3,
        ST_STABLE_COUNT   = 4'd4,
        ST_STABLE_WEIGH   = 4'd5,
        ST_TARING         = 4'd6,
        ST_SAMPLE_SET     = 4'd7,
        ST_UNSTABLE_REJ   = 4'd8,
        ST_TOO_LOW        = 4'd9,
        ST_WEIGH_MODE     = 4'd10,
        ST_COUNT_MODE     = 4'd11
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_CNT  = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic cnt_wr;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

    // quotient/numerator length of the count divider
    function automatic int f_div_len(input int wb);
        f_div_len = ((wb > CNT_W) ? wb : CNT_W) + 1;
    endfunction

endpackage

// File: rtl/core/counting_scale_mode_controller.sv
// top level of the counting scale mode controller
// sequence: an item that needs no count division goes from accept straight to the output load;
//   a stable counting reading is first divided by the piece weight (quotient DIV_LEN =
//   max(WEIGHT_BITS, 23) + 1 bits, 25 by default), then its count is written before the load
// throughput: one item at a time; the restoring divider gives one quotient bit per cycle
// the next item is taken while the previous result still waits in the output register
// reset (synchronous, active low): weighing mode, zero piece weight and count,
//   status init, minimum sample weight 1000 mg
module counting_scale_mode_controller #(
    parameter int WEIGHT_BITS = csmc_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic signed [WEIGHT_BITS-1:0] i_weight,
    input  logic                          i_stable,
    input  logic                          i_overload,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_mode,
    output logic [csmc_pkg::CNT_W-1:0]    o_item_count,
    output logic [3:0]                    o_status,
    output logic                          o_tare_request,
    output logic                          o_save_request,
    output logic [csmc_pkg::CNT_W-1:0]    o_piece_weight_out,
    // minimum sample weight register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [csmc_pkg::CNT_W-1:0]    i_cfg_data
);

    csmc_pkg::t_ctl_cmd ctl_cmd;
    csmc_pkg::t_dp_stat dp_stat;

    // the register is a plain flop, a write is always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: accept, divide, write count, load output
    csmc_ctrl #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (ctl_cmd)
    );

    // state, decode, divider and output register
    csmc_dp #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (ctl_cmd),
        .o_stat             (dp_stat),
        .i_command          (i_command),
        .i_weight           (i_weight),
        .i_stable           (i_stable),
        .i_overload         (i_overload),
        .i_cfg_wr           (i_cfg_valid & o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_mode             (o_mode),
        .o_item_count       (o_item_count),
        .o_status           (o_status),
        .o_tare_request     (o_tare_request),
        .o_save_request     (o_save_request),
        .o_piece_weight_out (o_piece_weight_out)
    );

endmodule

// File: rtl/core/csmc_ctrl.sv
// controller state machine: sequences accept, divide, count write and output load
module csmc_ctrl #(
    parameter int WEIGHT_BITS = csmc_pkg::WEIGHT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  csmc_pkg::t_dp_stat i_stat,
    output csmc_pkg::t_ctl_cmd o_cmd
);

    localparam int DIV_LEN = csmc_pkg::f_div_len(WEIGHT_BITS);
    localparam int STEP_W  = $clog2(DIV_LEN);

    csmc_pkg::t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    logic              last_step;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_step = (r_step == STEP_W'(DIV_LEN - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csmc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.need_div ? csmc_pkg::S_DIV : csmc_pkg::S_OUT;
                end
            end
            csmc_pkg::S_DIV: begin
                if (last_step) begin
                    n_state = csmc_pkg::S_CNT;
                end
            end
            csmc_pkg::S_CNT: begin
                n_state = csmc_pkg::S_OUT;
            end
            csmc_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = csmc_pkg::S_IDLE;
                end
            end
            default: n_state = csmc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        n_step     = r_step;
        unique case (r_state)
            csmc_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                n_step       = '0;
            end
            csmc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
            end
            csmc_pkg::S_CNT: begin
                o_cmd.cnt_wr = 1'b1;
            end
            csmc_pkg::S_OUT: begin
                o_cmd.load_out = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csmc_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while the first is still in work");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while its item waits");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csmc_pkg::S_DIV) |-> (r_step <= STEP_W'(DIV_LEN - 1)))
        else $error("divider step count out of range");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == csmc_pkg::S_OUT))
        else $error("result shown without an output load");

endmodule

// File: rtl/core/csmc_dp.sv
// datapath: mode/count/status state, command decode, count divider, output register
module csmc_dp #(
    parameter int WEIGHT_BITS = csmc_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csmc_pkg::t_ctl_cmd            i_cmd,
    output csmc_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                    i_command,
    input  logic signed [WEIGHT_BITS-1:0] i_weight,
    input  logic                          i_stable,
    input  logic                          i_overload,
    input  logic                          i_cfg_wr,
    input  logic [csmc_pkg::CNT_W-1:0]    i_cfg_data,
    output logic [1:0]                    o_mode,
    output logic [csmc_pkg::CNT_W-1:0]    o_item_count,
    output logic [3:0]                    o_status,
    output logic                          o_tare_request,
    output logic                          o_save_request,
    output logic [csmc_pkg::CNT_W-1:0]    o_piece_weight_out
);

    localparam int CW      = csmc_pkg::CNT_W;
    localparam int DIV_LEN = csmc_pkg::f_div_len(WEIGHT_BITS);
    localparam int EXT_W   = DIV_LEN + 1;
    localparam int DVS_W   = CW + 1;

    // architectural state
    csmc_pkg::t_mode             r_mode, n_mode;
    csmc_pkg::t_status           r_status, n_status;
    logic [CW-1:0]               r_piece, n_piece;
    logic [CW-1:0]               r_count, n_count;
    logic signed [WEIGHT_BITS-1:0] r_last_w, n_last_w;
    logic                        r_last_st, n_last_st;
    logic [CW-1:0]               r_min;
    logic                        r_tare, n_tare;
    logic                        r_save, n_save;

    // divider
    logic [DIV_LEN-1:0]          r_quo;
    logic [DVS_W-1:0]            r_rem;
    logic [DVS_W-1:0]            r_dvs;
    logic [DVS_W:0]              rem_sh;
    logic [DVS_W:0]              rem_sub;
    logic                        q_bit;
    logic [CW-1:0]               quo_sat;

    // evaluator
    csmc_pkg::t_cmd              cmd;
    logic                        ev_en;
    logic signed [WEIGHT_BITS-1:0] ev_w;
    logic                        ev_st;
    logic                        ev_ov;
    logic [CW-1:0]               ev_piece;
    csmc_pkg::t_mode             ev_mode_in;
    csmc_pkg::t_mode             ev_mode;
    csmc_pkg::t_status           ev_status;
    logic                        ev_zero;
    logic                        ev_div;
    logic signed [EXT_W-1:0]     w2;
    logic signed [EXT_W-1:0]     p_ext;
    logic signed [EXT_W-1:0]     num_sum;
    logic                        half_ok;
    logic signed [EXT_W-1:0]     last_ext;
    logic                        sample_ok;
    logic                        last_over;
    logic [CW-1:0]               piece_new;

    assign cmd = csmc_pkg::t_cmd'(i_command);

    // sample candidate from the stored reading
    assign last_ext  = EXT_W'(r_last_w);
    assign sample_ok = r_last_st && (last_ext >= $signed(EXT_W'({1'b0, r_min})));
    assign last_over = last_ext > $signed(EXT_W'({1'b0, csmc_pkg::MAX_CNT}));
    assign piece_new = last_over ? csmc_pkg::MAX_CNT : CW'(r_last_w);

    // evaluator operand select
    always_comb begin
        ev_w       = r_last_w;
        ev_st      = r_last_st;
        ev_ov      = 1'b0;
        ev_piece   = r_piece;
        ev_mode_in = csmc_pkg::MODE_COUNT;
        case (cmd)
            csmc_pkg::CMD_READ: begin
                ev_w       = i_weight;
                ev_st      = i_stable;
                ev_ov      = i_overload;
                ev_mode_in = r_mode;
            end
            csmc_pkg::CMD_SAMPLE: begin
                ev_st    = 1'b1;
                ev_piece = piece_new;
            end
            default: ev_w = r_last_w;
        endcase
    end

    assign w2      = EXT_W'(ev_w) <<< 1;
    assign p_ext   = $signed(EXT_W'({1'b0, ev_piece}));
    assign half_ok = (w2 >= p_ext);
    assign num_sum = w2 + p_ext;

    // reading evaluation
    always_comb begin
        ev_zero = 1'b0;
        ev_div  = 1'b0;
        if (ev_ov) begin
            ev_mode   = csmc_pkg::MODE_ERROR;
            ev_status = csmc_pkg::ST_OVERLOAD;
            ev_zero   = 1'b1;
        end else begin
            if (ev_mode_in == csmc_pkg::MODE_ERROR) begin
                ev_mode = (ev_piece > CW'(1)) ? csmc_pkg::MODE_COUNT : csmc_pkg::MODE_WEIGH;
            end else begin
                ev_mode = ev_mode_in;
            end
            if (ev_mode == csmc_pkg::MODE_COUNT && ev_st) begin
                if (ev_piece > CW'(1) && half_ok) begin
                    ev_div = 1'b1;
                end else begin
                    ev_zero = 1'b1;
                end
            end else if (ev_mode == csmc_pkg::MODE_WEIGH) begin
                ev_zero = 1'b1;
            end
            if (!ev_st) begin
                ev_status = csmc_pkg::ST_UNSTABLE;
            end else if (ev_mode == csmc_pkg::MODE_COUNT && ev_piece == '0) begin
                ev_status = csmc_pkg::ST_NO_PIECE;
            end else if (ev_mode == csmc_pkg::MODE_COUNT) begin
                ev_status = csmc_pkg::ST_STABLE_COUNT;
            end else begin
                ev_status = csmc_pkg::ST_STABLE_WEIGH;
            end
        end
    end

    // command decode
    always_comb begin
        n_mode    = r_mode;
        n_status  = r_status;
        n_piece   = r_piece;
        n_count   = r_count;
        n_last_w  = r_last_w;
        n_last_st = r_last_st;
        n_tare    = 1'b0;
        n_save    = 1'b0;
        ev_en     = 1'b0;
        if (cmd == csmc_pkg::CMD_READ) begin
            ev_en     = 1'b1;
            n_last_w  = i_weight;
            n_last_st = i_stable;
        end else if (r_mode != csmc_pkg::MODE_ERROR) begin
            unique case (cmd)
                csmc_pkg::CMD_TARE: begin
                    n_tare   = 1'b1;
                    n_status = csmc_pkg::ST_TARING;
                end
                csmc_pkg::CMD_SAMPLE: begin
                    if (sample_ok) begin
                        n_piece = piece_new;
                        n_save  = piece_new > CW'(1);
                        ev_en   = 1'b1;
                    end else if (!r_last_st) begin
                        n_status = csmc_pkg::ST_UNSTABLE_REJ;
                    end else begin
                        n_status = csmc_pkg::ST_TOO_LOW;
                    end
                end
                csmc_pkg::CMD_TOGGLE: begin
                    case (r_mode)
                        csmc_pkg::MODE_COUNT: begin
                            n_mode   = csmc_pkg::MODE_WEIGH;
                            n_count  = '0;
                            n_status = csmc_pkg::ST_WEIGH_MODE;
                        end
                        csmc_pkg::MODE_WEIGH: begin
                            if (r_piece > CW'(1)) begin
                                ev_en = 1'b1;
                            end else begin
                                n_status = csmc_pkg::ST_NO_PIECE;
                            end
                        end
                        default: n_mode = r_mode;
                    endcase
                end
                default: n_mode = r_mode;
            endcase
        end
        if (ev_en) begin
            n_mode   = ev_mode;
            n_status = ev_status;
            if (ev_zero) begin
                n_count = '0;
            end
        end
    end

    assign o_stat.need_div = ev_en && ev_div;

    // restoring divider, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_quo[DIV_LEN-1]};
    assign q_bit   = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign quo_sat = (|r_quo[DIV_LEN-1:CW]) ? csmc_pkg::MAX_CNT : r_quo[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= csmc_pkg::MODE_WEIGH;
            r_status  <= csmc_pkg::ST_INIT;
            r_piece   <= '0;
            r_count   <= '0;
            r_last_w  <= '0;
            r_last_st <= 1'b0;
            r_min     <= csmc_pkg::MIN_SAMPLE_RST;
        end else begin
            if (i_cfg_wr) begin
                r_min <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_mode    <= n_mode;
                r_status  <= n_status;
                r_piece   <= n_piece;
                r_count   <= n_count;
                r_last_w  <= n_last_w;
                r_last_st <= n_last_st;
            end else if (i_cmd.cnt_wr) begin
                r_count <= quo_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tare <= n_tare;
            r_save <= n_save;
            r_quo  <= num_sum[DIV_LEN-1:0];
            r_rem  <= '0;
            r_dvs  <= {ev_piece, 1'b0};
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_LEN-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mode             <= r_mode;
            o_item_count       <= r_count;
            o_status           <= r_status;
            o_tare_request     <= r_tare;
            o_save_request     <= r_save;
            o_piece_weight_out <= r_piece;
        end
    end

endmodule

// File: verif/counting_scale_mode_controller_tb.sv
// self-checking testbench for the counting scale mode controller: directed and random commands
module counting_scale_mode_controller_tb;
    import csmc_pkg::*;

    localparam int     WB             = WEIGHT_BITS_DEF;
    localparam longint W_MAX          = (longint'(1) << (WB - 1)) - 1;
    localparam longint W_MIN          = -(longint'(1) << (WB - 1));
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     WATCHDOG_LIMIT = 4000;

    // one result item as the display panel sees it
    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] item_count;
        logic [3:0]       status;
        logic             tare;
        logic             save;
        logic [CNT_W-1:0] piece;
    } panel_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_command = CMD_READ;
    logic signed [WB-1:0] i_weight = '0;
    logic                 i_stable = 1'b0;
    logic                 i_overload = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_mode;
    logic [CNT_W-1:0]     o_item_count;
    logic [3:0]           o_status;
    logic                 o_tare_request;
    logic                 o_save_request;
    logic [CNT_W-1:0]     o_piece_weight_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CNT_W-1:0]     i_cfg_data = '0;

    counting_scale_mode_controller dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_weight           (i_weight),
        .i_stable           (i_stable),
        .i_overload         (i_overload),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_mode             (o_mode),
        .o_item_count       (o_item_count),
        .o_status           (o_status),
        .o_tare_request     (o_tare_request),
        .o_save_request     (o_save_request),
        .o_piece_weight_out (o_piece_weight_out),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // scale state as the predictor tracks it
    t_mode            scale_mode = MODE_WEIGH;
    t_status          scale_status = ST_INIT;
    logic [CNT_W-1:0] scale_piece = '0;
    logic [CNT_W-1:0] scale_count = '0;
    logic [CNT_W-1:0] min_sample = MIN_SAMPLE_RST;
    longint           last_reading = 0;
    logic             last_reading_stable = 1'b0;

    panel_t pending_panels[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit offering = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int n_errors = 0;
    int n_items = 0;
    int n_live = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_cfg_writes = 0;
    int n_pieces = 0;
    int n_overloads = 0;
    int n_divided = 0;
    int n_holds = 0;
    int max_count = 0;

    // one reading: overload, recovery from error, then count and status
    function automatic void weigh_reading(input longint w, input logic st, input logic ov);
        longint p;
        longint q;
        last_reading = w;
        last_reading_stable = st;
        if (ov) begin
            scale_mode = MODE_ERROR;
            scale_count = '0;
            scale_status = ST_OVERLOAD;
            n_overloads++;
            return;
        end
        if (scale_mode == MODE_ERROR)
            scale_mode = (scale_piece > 1) ? MODE_COUNT : MODE_WEIGH;
        if (scale_mode == MODE_COUNT && st) begin
            if (scale_piece > 1) begin
                p = longint'(scale_piece);
                n_divided++;
                if (2 * w >= p) begin
                    // round half up
                    q = (2 * w + p) / (2 * p);
                    scale_count = (q > longint'(MAX_CNT)) ? MAX_CNT : q[CNT_W-1:0];
                end else begin
                    scale_count = '0;
                end
                if (int'(scale_count) > max_count)
                    max_count = int'(scale_count);
            end else begin
                scale_count = '0;
            end
        end else if (scale_mode == MODE_WEIGH) begin
            scale_count = '0;
        end
        if (!st)
            scale_status = ST_UNSTABLE;
        else if (scale_mode == MODE_COUNT && scale_piece == 0)
            scale_status = ST_NO_PIECE;
        else if (scale_mode == MODE_COUNT)
            scale_status = ST_STABLE_COUNT;
        else
            scale_status = ST_STABLE_WEIGH;
    endfunction

    // applies one command to the scale state and returns the panel it shows
    function automatic panel_t apply_command(input t_cmd c, input logic signed [WB-1:0] w,
                                             input logic st, input logic ov);
        panel_t r;
        r.tare = 1'b0;
        r.save = 1'b0;
        if (c == CMD_READ) begin
            weigh_reading(longint'(w), st, ov);
        end else if (scale_mode != MODE_ERROR) begin
            case (c)
                CMD_TARE: begin
                    r.tare = 1'b1;
                    scale_status = ST_TARING;
                end
                CMD_SAMPLE: begin
                    if (last_reading_stable && last_reading >= longint'(min_sample)) begin
                        scale_piece = (last_reading > longint'(MAX_CNT)) ?
                                      MAX_CNT : last_reading[CNT_W-1:0];
                        scale_mode = MODE_COUNT;
                        r.save = (scale_piece > 1);
                        n_pieces++;
                        // the stored reading is counted again as a stable one
                        weigh_reading(last_reading, 1'b1, 1'b0);
                    end else if (!last_reading_stable) begin
                        scale_status = ST_UNSTABLE_REJ;
                    end else begin
                        scale_status = ST_TOO_LOW;
                    end
                end
                default: begin
                    if (scale_mode == MODE_COUNT) begin
                        scale_mode = MODE_WEIGH;
                        scale_count = '0;
                        scale_status = ST_WEIGH_MODE;
                    end else if (scale_piece > 1) begin
                        scale_mode = MODE_COUNT;
                        weigh_reading(last_reading, last_reading_stable, 1'b0);
                    end else begin
                        scale_status = ST_NO_PIECE;
                    end
                end
            endcase
        end
        r.mode = scale_mode;
        r.item_count = scale_count;
        r.status = scale_status;
        r.piece = scale_piece;
        return r;
    endfunction

    function automatic logic signed [WB-1:0] to_weight(input longint v);
        longint c;
        c = (v > W_MAX) ? W_MAX : ((v < W_MIN) ? W_MIN : v);
        return c[WB-1:0];
    endfunction

    function automatic logic signed [WB-1:0] rand_weight();
        logic [31:0] r;
        case ($urandom_range(5))
            0: r = $urandom;
            1: r = $urandom_range(0, 3000);
            2: r = -$urandom_range(0, 3000);
            3: r = $urandom_range(0, 100000);
            4: r = {9'b0, 23'($urandom)};
            default: begin
                case ($urandom_range(4))
                    0: return to_weight(W_MAX);
                    1: return to_weight(W_MIN);
                    2: r = 32'd0;
                    3: r = 32'd1;
                    default: r = '1;
                endcase
            end
        endcase
        return r[WB-1:0];
    endfunction

    // weights near whole and half multiples of the current piece, or a random weight
    function automatic logic signed [WB-1:0] count_weight();
        longint p;
        longint k;
        longint j;
        longint v;
        p = longint'(scale_piece);
        if (p < 2 || $urandom_range(2) == 0)
            return rand_weight();
        k = $urandom_range(0, (p > 200000) ? 3 : 40);
        j = $urandom_range(0, int'(p - 1));
        case ($urandom_range(3))
            0: v = k * p + p / 2;
            1: v = k * p + (p - 1) / 2;
            2: v = k * p + j;
            default: v = k * p - j;
        endcase
        return to_weight(v);
    endfunction

    // offers one item, holds it until taken, then records the expected panel
    task automatic send_cmd(input t_cmd c, input logic signed [WB-1:0] w,
                            input logic st, input logic ov);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= c;
        i_weight   <= w;
        i_stable   <= st;
        i_overload <= ov;
        offering = 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n_items++;
        if (c == CMD_READ || scale_mode != MODE_ERROR)
            n_live++;
        else
            n_ignored++;
        pending_panels.push_back(apply_command(c, w, st, ov));
    endtask

    task automatic drain_results();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_panels.size() != 0)
            @(posedge i_clk);
    endtask

    // register writes only once the block has gone idle
    task automatic write_min_sample(input logic [CNT_W-1:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        min_sample = v;
        n_cfg_writes++;
    endtask

    task automatic test_idle_commands();
        send_cmd(CMD_TOGGLE, '0, 1'b0, 1'b0);        // no piece yet
        send_cmd(CMD_TARE, '0, 1'b0, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);        // last reading unstable
        send_cmd(CMD_READ, 24'sd500, 1'b1, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);        // below the minimum sample
    endtask

    task automatic test_weight_extremes();
        send_cmd(CMD_READ, to_weight(W_MIN), 1'b1, 1'b0);
        send_cmd(CMD_READ, to_weight(W_MAX), 1'b1, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);        // piece takes the largest 23-bit value
        send_cmd(CMD_READ, '0, 1'b1, 1'b0);
    endtask

    task automatic test_overload_recovery();
        send_cmd(CMD_READ, 24'sd4194304, 1'b1, 1'b1);
        send_cmd(CMD_TARE, '1, 1'b1, 1'b1);          // ignored in error mode
        send_cmd(CMD_TOGGLE, '0, 1'b0, 1'b0);
        send_cmd(CMD_READ, 24'sd4194304, 1'b1, 1'b0); // back to counting
        send_cmd(CMD_TOGGLE, '0, 1'b0, 1'b0);
        send_cmd(CMD_TOGGLE, '0, 1'b0, 1'b0);        // counting again, reading recounted
    endtask

    task automatic test_tiny_pieces();
        write_min_sample('0);
        send_cmd(CMD_READ, '0, 1'b1, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);        // zero piece, no save
        send_cmd(CMD_READ, 24'sd1, 1'b1, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);        // one milligram piece
        send_cmd(CMD_READ, 24'sd5, 1'b0, 1'b1);
        send_cmd(CMD_READ, 24'sd10, 1'b1, 1'b0);     // recovers into weighing
        send_cmd(CMD_TOGGLE, '0, 1'b0, 1'b0);
    endtask

    task automatic test_rounding();
        send_cmd(CMD_READ, 24'sd4, 1'b1, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);
        send_cmd(CMD_READ, 24'sd6, 1'b1, 1'b0);      // one and a half rounds up
        send_cmd(CMD_READ, 24'sd1, 1'b1, 1'b0);      // below half a piece
        send_cmd(CMD_READ, 24'sd10, 1'b1, 1'b0);
    endtask

    task automatic test_min_sample_limits();
        write_min_sample(MAX_CNT);
        send_cmd(CMD_READ, to_weight(W_MAX), 1'b1, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);
    endtask

    task automatic test_output_backpressure();
        send_cmd(CMD_READ, 24'sd20000, 1'b1, 1'b0);
        send_cmd(CMD_SAMPLE, '0, 1'b0, 1'b0);
        // receiver holds off while items keep coming, so the block fills up
        hold_req = 1'b1;
        repeat (12)
            send_cmd(CMD_READ, count_weight(), 1'b1, 1'b0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int target, input int min_lo, input int min_hi);
        int     start;
        int     kind;
        longint v;
        longint j;
        write_min_sample($urandom_range(min_lo, min_hi));
        start = n_live;
        while (n_live - start < target) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                // weigh a sample, take it as the piece, then count on top of it
                j = $urandom_range(0, 50);
                case ($urandom_range(3))
                    0: v = longint'(min_sample);
                    1: v = longint'(min_sample) + j;
                    2: v = $urandom_range(int'(min_sample), int'(W_MAX));
                    default: v = longint'(rand_weight());
                endcase
                send_cmd(CMD_READ, to_weight(v), ($urandom_range(7) != 0), 1'b0);
                send_cmd(CMD_SAMPLE, rand_weight(), $urandom_range(1), $urandom_range(1));
                repeat ($urandom_range(2, 8))
                    send_cmd(CMD_READ, count_weight(), ($urandom_range(4) != 0), 1'b0);
            end else if (kind < 6) begin
                repeat ($urandom_range(1, 4))
                    send_cmd(CMD_READ, count_weight(), $urandom_range(1), 1'b0);
            end else if (kind == 6) begin
                send_cmd(CMD_READ, rand_weight(), $urandom_range(1), 1'b1);
                if ($urandom_range(1))
                    send_cmd(t_cmd'($urandom_range(1, 3)), rand_weight(), $urandom_range(1),
                             $urandom_range(1));
                send_cmd(CMD_READ, count_weight(), $urandom_range(1), 1'b0);
            end else if (kind == 7) begin
                send_cmd(CMD_TOGGLE, rand_weight(), $urandom_range(1), $urandom_range(1));
                send_cmd(CMD_READ, count_weight(), $urandom_range(1), 1'b0);
            end else begin
                send_cmd(t_cmd'($urandom_range(3)), rand_weight(), $urandom_range(1),
                         ($urandom_range(7) == 0));
            end
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        panel_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_panels.size() == 0) begin
                $display("%0t: result item with nothing pending, mode %0d count %0d status %0d",
                         $time, o_mode, o_item_count, o_status);
                n_errors++;
            end else begin
                want = pending_panels.pop_front();
                check_field("mode", want.mode, o_mode);
                check_field("item_count", want.item_count, o_item_count);
                check_field("status", want.status, o_status);
                check_field("tare_request", want.tare, o_tare_request);
                check_field("save_request", want.save, o_save_request);
                check_field("piece_weight_out", want.piece, o_piece_weight_out);
                n_checked++;
            end
        end
    end

    // receiver: random stalls, or a long counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_req = 1'b0;
            n_holds++;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results still pending",
                     $time, WATCHDOG_LIMIT, pending_panels.size());
            $display("counting_scale_mode_controller_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        send_idle_pct = 15;
        recv_idle_pct = 66;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_weight_extremes();
        test_overload_recovery();
        test_tiny_pieces();
        test_rounding();
        test_min_sample_limits();
        test_random_traffic(450, 500, 3000);

        send_idle_pct = 66;
        recv_idle_pct = 15;
        test_random_traffic(450, 0, 20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(400, 1000, 1000);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d command items (%0d ignored in error mode), %0d results, %0d min sample writes",
                 n_items, n_ignored, n_checked, n_cfg_writes);
        $display("%0d pieces taken, %0d overloads, %0d divided counts up to %0d, %0d long output holds",
                 n_pieces, n_overloads, n_divided, max_count, n_holds);
        if (n_errors == 0)
            $display("counting_scale_mode_controller_tb: clean");
        else
            $display("counting_scale_mode_controller_tb: errors");
        $finish;
    end

endmodule
